### hdl/kerp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kerp_pkg
// Types and codes shared by the key-exchange response record parser.
// ----------------------------------------------------------------------------
package kerp_pkg;

	// one byte of the response stream
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [2:0]  cookie_slot;
		logic        last_of_field;
		logic [2:0]  status;
		logic [15:0] server_error_code;
		logic [15:0] chosen_aead;
		logic [15:0] server_port;
		logic [3:0]  cookies_kept;
		logic        is_last;
	} result_t;

	// result kinds
	localparam logic [1:0] K_COOKIE  = 2'd0;
	localparam logic [1:0] K_NAME    = 2'd1;
	localparam logic [1:0] K_VERDICT = 2'd2;

	// verdict status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_BAD      = 3'd2;
	localparam logic [2:0] ST_CRIT     = 3'd3;
	localparam logic [2:0] ST_NO_PROTO = 3'd4;
	localparam logic [2:0] ST_NO_AEAD  = 3'd5;
	localparam logic [2:0] ST_WARNING  = 3'd6;
	localparam logic [2:0] ST_SRV_ERR  = 3'd7;

	// record kinds (type word without the critical bit)
	localparam logic [14:0] RK_END      = 15'd0;
	localparam logic [14:0] RK_PROTOCOL = 15'd1;
	localparam logic [14:0] RK_ERROR    = 15'd2;
	localparam logic [14:0] RK_WARNING  = 15'd3;
	localparam logic [14:0] RK_AEAD     = 15'd4;
	localparam logic [14:0] RK_COOKIE   = 15'd5;
	localparam logic [14:0] RK_NAME     = 15'd6;
	localparam logic [14:0] RK_PORT     = 15'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_AEAD_FIRST  = 2'd0;
	localparam logic [1:0] CFG_AEAD_SECOND = 2'd1;
	localparam logic [1:0] CFG_AEAD_THIRD  = 2'd2;

	localparam logic [15:0] AEAD_FIRST_RST  = 16'd15;
	localparam logic [15:0] AEAD_SECOND_RST = 16'd17;
	localparam logic [15:0] AEAD_THIRD_RST  = 16'd0;

	// printable range for server name bytes
	localparam logic [7:0] NAME_MIN = 8'h21;
	localparam logic [7:0] NAME_MAX = 8'h7E;

	// result queue
	localparam int         QDEPTH = 4;
	localparam logic [2:0] QFULL  = 3'd4;

endpackage : kerp_pkg
`default_nettype wire

### hdl/nts_ke_response_record_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_ke_response_record_parser_core
// Byte-serial parser for key-exchange response records: streams cookie and
// server name bytes and closes each message with one verdict.
// ----------------------------------------------------------------------------
// a byte is held in the input register, and the results it raises are written
//   into the result queue, which offers them on the output in order
// throughput: 1 byte per cycle; the input register holds while the 4-entry
//   result queue has more than two entries, as one byte can raise two results
// reset: parse state, queue pointers and valid flag cleared at once by arst_n;
//   the aead registers return to 15, 17 and 0
module nts_ke_response_record_parser_core
	import kerp_pkg::*;
#(
	parameter int MAX_COOKIES     = 8,
	parameter int MAX_SERVER_NAME = 255
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	// byte channel
	input  wire logic     byte_valid,
	output logic          byte_stall,
	input  wire in_item_t byte_data,
	// result channel
	output logic          result_valid,
	input  wire logic     result_stall,
	output result_t       result_data,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int              CW           = $clog2(MAX_COOKIES + 1);
	localparam logic [CW-1:0]   COOKIE_LIMIT = CW'(MAX_COOKIES);
	localparam logic [15:0]     NAME_LIMIT   = 16'(MAX_SERVER_NAME);

	// configuration registers
	logic [15:0] aead_first_q, aead_second_q, aead_third_q;

	// input register
	logic     valid_s1;
	in_item_t data_s1;
	logic     adv;

	// parse state
	logic [1:0]    hcnt_q;
	logic [23:0]   hword_q;
	logic [14:0]   rkind_q;
	logic [15:0]   body_q;
	logic [2:0]    fault_q;
	logic [7:0]    whb_q;
	logic          phase_q;
	logic          wseen_q;
	logic          proto_q;
	logic          ntpv4_q;
	logic [15:0]   aead_q;
	logic [15:0]   port_q;
	logic [CW-1:0] cookies_q;
	logic          verdict_q;

	// next state
	logic [1:0]    n_hcnt;
	logic [23:0]   n_hword;
	logic [14:0]   n_rkind;
	logic [15:0]   n_body;
	logic [2:0]    n_fault;
	logic [7:0]    n_whb;
	logic          n_phase;
	logic          n_wseen;
	logic          n_proto;
	logic          n_ntpv4;
	logic [15:0]   n_aead;
	logic [15:0]   n_port;
	logic [CW-1:0] n_cookies;
	logic          n_verdict;

	// results raised by the byte in the input register
	logic        byte_ok;
	logic [1:0]  byte_kind;
	logic [2:0]  byte_slot;
	logic        byte_last;
	logic        fin_v;
	logic [2:0]  fin_st;
	logic [15:0] fin_code;
	logic        eob_v;
	result_t     res_byte, res_fin, res_eob, res_a, res_b;
	logic [1:0]  push_cnt;

	// result queue
	result_t     queue_q [QDEPTH];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  fill_q;
	logic        pop;

	assign adv        = valid_s1 && (fill_q <= 3'd2);
	assign byte_stall = valid_s1 && !adv;
	assign pop        = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aead_first_q  <= AEAD_FIRST_RST;
			aead_second_q <= AEAD_SECOND_RST;
			aead_third_q  <= AEAD_THIRD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_AEAD_FIRST:  aead_first_q  <= cfg_data;
				CFG_AEAD_SECOND: aead_second_q <= cfg_data;
				CFG_AEAD_THIRD:  aead_third_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_s1 <= byte_data;
		end
	end

	function automatic logic aead_ok(input logic [15:0] id, input logic [15:0] a,
		input logic [15:0] b, input logic [15:0] c);
		aead_ok = (id != 16'd0) && (id == a || id == b || id == c);
	endfunction

	always_comb begin : parse
		logic [7:0]  b;
		logic [15:0] len;
		logic [15:0] word;
		logic [15:0] fword;
		logic        do_fin;

		b      = data_s1.data_byte;
		len    = '0;
		word   = '0;
		fword  = '0;
		do_fin = 1'b0;

		n_hcnt    = hcnt_q;
		n_hword   = hword_q;
		n_rkind   = rkind_q;
		n_body    = body_q;
		n_fault   = fault_q;
		n_whb     = whb_q;
		n_phase   = phase_q;
		n_wseen   = wseen_q;
		n_proto   = proto_q;
		n_ntpv4   = ntpv4_q;
		n_aead    = aead_q;
		n_port    = port_q;
		n_cookies = cookies_q;
		n_verdict = verdict_q;

		byte_ok   = 1'b0;
		byte_kind = K_COOKIE;
		byte_slot = '0;
		byte_last = 1'b0;
		fin_v     = 1'b0;
		fin_st    = ST_OK;
		fin_code  = '0;
		eob_v     = 1'b0;

		if (!verdict_q) begin
			if (body_q == 16'd0) begin
				if (hcnt_q != 2'd3) begin
					n_hword = {hword_q[15:0], b};
					n_hcnt  = hcnt_q + 2'd1;
				end else begin
					len     = {hword_q[7:0], b};
					n_rkind = hword_q[22:8];
					n_body  = len;
					n_hcnt  = '0;
					n_hword = '0;
					n_fault = ST_OK;
					n_phase = 1'b0;
					n_whb   = '0;
					n_wseen = 1'b0;
					n_proto = 1'b0;
					// length faults wait for the body end so truncation wins
					case (n_rkind) inside
						RK_ERROR, RK_WARNING, RK_PORT: if (len != 16'd2) n_fault = ST_BAD;
						RK_END:                        if (len != 16'd0) n_fault = ST_BAD;
						RK_PROTOCOL, RK_AEAD:          if (len[0]) n_fault = ST_BAD;
						RK_COOKIE:                     ;
						RK_NAME:                       if (len > NAME_LIMIT) n_fault = ST_BAD;
						default:                       if (hword_q[23]) n_fault = ST_CRIT;
					endcase
					do_fin = (len == 16'd0);
				end
			end else begin
				n_body    = body_q - 16'd1;
				byte_last = (n_body == 16'd0);
				if (rkind_q == RK_COOKIE) begin
					if (cookies_q < COOKIE_LIMIT) begin
						byte_ok   = 1'b1;
						byte_kind = K_COOKIE;
						byte_slot = 3'(cookies_q);
					end
				end else if (fault_q == ST_OK) begin
					if (rkind_q == RK_NAME) begin
						if (b < NAME_MIN || b > NAME_MAX) begin
							n_fault = ST_BAD;
						end else begin
							byte_ok   = 1'b1;
							byte_kind = K_NAME;
						end
					end else if (!phase_q) begin
						n_whb   = b;
						n_phase = 1'b1;
					end else begin
						word    = {whb_q, b};
						n_phase = 1'b0;
						case (rkind_q) inside
							RK_PROTOCOL: if (word == 16'd0) n_proto = 1'b1;
							RK_ERROR, RK_WARNING, RK_AEAD, RK_PORT: begin
								if (!wseen_q) begin
									n_hword = {8'd0, word};
									n_wseen = 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				do_fin = (n_body == 16'd0);
			end

			if (do_fin) begin
				fword = n_hword[15:0];
				if (n_fault != ST_OK) begin
					fin_v  = 1'b1;
					fin_st = n_fault;
				end else begin
					case (n_rkind) inside
						RK_END: begin
							fin_v  = 1'b1;
							fin_st = (n_ntpv4 && n_aead != 16'd0) ? ST_OK : ST_BAD;
						end
						RK_PROTOCOL: begin
							if (n_proto) n_ntpv4 = 1'b1;
							else begin
								fin_v  = 1'b1;
								fin_st = ST_NO_PROTO;
							end
						end
						RK_ERROR: begin
							fin_v    = 1'b1;
							fin_st   = ST_SRV_ERR;
							fin_code = fword;
						end
						RK_WARNING: begin
							fin_v  = 1'b1;
							fin_st = ST_WARNING;
						end
						RK_AEAD: begin
							if (n_wseen && aead_ok(fword, aead_first_q, aead_second_q,
								aead_third_q)) begin
								n_aead = fword;
							end else begin
								fin_v  = 1'b1;
								fin_st = ST_NO_AEAD;
							end
						end
						RK_COOKIE: if (n_cookies < COOKIE_LIMIT) n_cookies = n_cookies + 1'b1;
						RK_PORT:   n_port = fword;
						default:   ;
					endcase
				end
				if (fin_v) n_verdict = 1'b1;
			end

			if (data_s1.end_of_buffer && !n_verdict) begin
				eob_v     = 1'b1;
				n_verdict = 1'b1;
			end
		end
	end

	always_comb begin
		res_byte               = '0;
		res_byte.kind          = byte_kind;
		res_byte.payload_byte  = data_s1.data_byte;
		res_byte.cookie_slot   = byte_slot;
		res_byte.last_of_field = byte_last;

		res_fin                   = '0;
		res_fin.kind              = K_VERDICT;
		res_fin.status            = fin_st;
		res_fin.server_error_code = fin_code;
		res_fin.chosen_aead       = n_aead;
		res_fin.server_port       = n_port;
		res_fin.cookies_kept      = 4'(n_cookies);
		res_fin.is_last           = 1'b1;

		res_eob                   = res_fin;
		res_eob.status            = ST_SHORT;
		res_eob.server_error_code = '0;

		// order: streamed byte, record verdict, buffer-end verdict
		if (byte_ok) begin
			res_a = res_byte;
			res_b = fin_v ? res_fin : res_eob;
		end else begin
			res_a = fin_v ? res_fin : res_eob;
			res_b = res_eob;
		end
		push_cnt = 2'(byte_ok) + 2'(fin_v) + 2'(eob_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q    <= '0;
			hword_q   <= '0;
			rkind_q   <= '0;
			body_q    <= '0;
			fault_q   <= ST_OK;
			whb_q     <= '0;
			phase_q   <= 1'b0;
			wseen_q   <= 1'b0;
			proto_q   <= 1'b0;
			ntpv4_q   <= 1'b0;
			aead_q    <= '0;
			port_q    <= '0;
			cookies_q <= '0;
			verdict_q <= 1'b0;
		end else if (adv) begin
			if (data_s1.end_of_buffer) begin
				// buffer end starts a fresh message
				hcnt_q    <= '0;
				hword_q   <= '0;
				rkind_q   <= '0;
				body_q    <= '0;
				fault_q   <= ST_OK;
				whb_q     <= '0;
				phase_q   <= 1'b0;
				wseen_q   <= 1'b0;
				proto_q   <= 1'b0;
				ntpv4_q   <= 1'b0;
				aead_q    <= '0;
				port_q    <= '0;
				cookies_q <= '0;
				verdict_q <= 1'b0;
			end else begin
				hcnt_q    <= n_hcnt;
				hword_q   <= n_hword;
				rkind_q   <= n_rkind;
				body_q    <= n_body;
				fault_q   <= n_fault;
				whb_q     <= n_whb;
				phase_q   <= n_phase;
				wseen_q   <= n_wseen;
				proto_q   <= n_proto;
				ntpv4_q   <= n_ntpv4;
				aead_q    <= n_aead;
				port_q    <= n_port;
				cookies_q <= n_cookies;
				verdict_q <= n_verdict;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (adv && push_cnt != 2'd0) begin
			queue_q[wr_q] <= res_a;
			if (push_cnt == 2'd2) queue_q[wr_q + 2'd1] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (adv) wr_q <= wr_q + push_cnt;
			if (pop) rd_q <= rd_q + 2'd1;
			fill_q <= fill_q + (adv ? 3'(push_cnt) : 3'd0) - 3'(pop);
		end
	end

	assign result_valid = (fill_q != 3'd0);
	assign result_data  = queue_q[rd_q];

	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= QFULL)
		else $error("result queue overfilled");

	a_quiet_after_verdict : assert property (@(posedge clk) disable iff (!arst_n)
		adv && verdict_q |-> push_cnt == 2'd0)
		else $error("result raised after the verdict");

	a_verdict_last : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.is_last == (result_data.kind == K_VERDICT)))
		else $error("is_last does not match a verdict");

	a_stall_held : assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && fill_q > 3'd2)
		else $error("input stalled with room in the queue");

endmodule : nts_ke_response_record_parser_core
`default_nettype wire

### dv/nts_ke_response_record_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nts_ke_response_record_parser_core_tb
// Feeds key-exchange response messages byte by byte, predicts the streamed
// cookie and server name bytes and the closing verdict of each message, and
// compares every result transaction against the prediction.
// ----------------------------------------------------------------------------
module nts_ke_response_record_parser_core_tb;
	import kerp_pkg::*;

	localparam int          MAX_COOKIES = 8;
	localparam int          MAX_NAME    = 255;
	localparam logic [15:0] PROTO_NTPV4 = 16'd0;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	in_item_t    byte_data;
	logic        result_valid;
	logic        result_stall;
	result_t     result_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	nts_ke_response_record_parser_core #(
		.MAX_COOKIES    (MAX_COOKIES),
		.MAX_SERVER_NAME(MAX_NAME)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// predicted parser state
	logic [15:0] aead_cfg [3] = '{AEAD_FIRST_RST, AEAD_SECOND_RST, AEAD_THIRD_RST};
	logic [1:0]  hdr_cnt;
	logic [23:0] hdr_word;
	logic [14:0] rec_kind;
	logic [15:0] body_left;
	logic [2:0]  fault;
	logic [7:0]  hi_byte;
	logic        word_phase;
	logic        word_seen;
	logic        proto_here;
	logic        ntpv4;
	logic [15:0] aead_taken;
	logic [15:0] port_taken;
	logic [3:0]  cookie_cnt;
	logic        verdict_done;

	result_t     results_due [$];
	logic [7:0]  msg_q [$];
	int          mismatches = 0;
	bit          sender_calm = 0;
	bit          receiver_calm = 0;
	bit          hold_req = 0;
	int          hold_len = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic void clear_state();
		hdr_cnt = '0; hdr_word = '0; rec_kind = '0; body_left = '0;
		fault = ST_OK; hi_byte = '0; word_phase = 1'b0; word_seen = 1'b0;
		proto_here = 1'b0; ntpv4 = 1'b0; aead_taken = '0; port_taken = '0;
		cookie_cnt = '0; verdict_done = 1'b0;
	endfunction

	function automatic void expect_byte(logic [1:0] k, logic [7:0] b, logic [2:0] slot,
			logic last);
		result_t r;
		r = '0;
		r.kind = k;
		r.payload_byte = b;
		r.cookie_slot = slot;
		r.last_of_field = last;
		results_due.push_back(r);
	endfunction

	function automatic void expect_verdict(logic [2:0] st, logic [15:0] code);
		result_t r;
		r = '0;
		r.kind = K_VERDICT;
		r.status = st;
		r.server_error_code = code;
		r.chosen_aead = aead_taken;
		r.server_port = port_taken;
		r.cookies_kept = cookie_cnt;
		r.is_last = 1'b1;
		results_due.push_back(r);
		verdict_done = 1'b1;
	endfunction

	function automatic void open_record(logic [7:0] b);
		logic        crit;
		logic [15:0] len;
		crit = hdr_word[23];
		len = {hdr_word[7:0], b};
		rec_kind = hdr_word[22:8];
		body_left = len;
		hdr_cnt = '0; hdr_word = '0; fault = ST_OK; word_phase = 1'b0;
		hi_byte = '0; word_seen = 1'b0; proto_here = 1'b0;
		case (rec_kind)
			RK_ERROR, RK_WARNING, RK_PORT: if (len != 16'd2) fault = ST_BAD;
			RK_END: if (len != 16'd0) fault = ST_BAD;
			RK_PROTOCOL, RK_AEAD: if (len[0]) fault = ST_BAD;
			RK_COOKIE: begin
			end
			RK_NAME: if (len > MAX_NAME) fault = ST_BAD;
			default: if (crit) fault = ST_CRIT;
		endcase
	endfunction

	function automatic void close_record();
		logic [15:0] w;
		w = hdr_word[15:0];
		if (fault != ST_OK) begin
			expect_verdict(fault, 16'd0);
			return;
		end
		case (rec_kind)
			RK_END: expect_verdict((ntpv4 && aead_taken != 0) ? ST_OK : ST_BAD, 16'd0);
			RK_PROTOCOL: begin
				if (proto_here) ntpv4 = 1'b1;
				else expect_verdict(ST_NO_PROTO, 16'd0);
			end
			RK_ERROR: expect_verdict(ST_SRV_ERR, w);
			RK_WARNING: expect_verdict(ST_WARNING, 16'd0);
			RK_AEAD: begin
				// an id of zero never matches, even against an unused register
				if (word_seen && w != 0 &&
						(w == aead_cfg[0] || w == aead_cfg[1] || w == aead_cfg[2]))
					aead_taken = w;
				else
					expect_verdict(ST_NO_AEAD, 16'd0);
			end
			RK_COOKIE: if (cookie_cnt < MAX_COOKIES) cookie_cnt++;
			RK_PORT: port_taken = w;
			default: begin
			end
		endcase
	endfunction

	function automatic void body_data(logic [7:0] b);
		logic        last;
		logic [15:0] w;
		last = (body_left == 0);
		if (rec_kind == RK_COOKIE) begin
			if (cookie_cnt < MAX_COOKIES) expect_byte(K_COOKIE, b, cookie_cnt[2:0], last);
			return;
		end
		if (fault != ST_OK) return;
		if (rec_kind == RK_NAME) begin
			if (b < NAME_MIN || b > NAME_MAX) fault = ST_BAD;
			else expect_byte(K_NAME, b, 3'd0, last);
			return;
		end
		if (!word_phase) begin
			hi_byte = b;
			word_phase = 1'b1;
			return;
		end
		word_phase = 1'b0;
		w = {hi_byte, b};
		case (rec_kind)
			RK_PROTOCOL: if (w == PROTO_NTPV4) proto_here = 1'b1;
			RK_ERROR, RK_WARNING, RK_AEAD, RK_PORT: begin
				// only the first word of the body is kept
				if (!word_seen) begin
					hdr_word = {8'h00, w};
					word_seen = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic eob);
		if (!verdict_done) begin
			if (body_left == 0) begin
				if (hdr_cnt < 2'd3) begin
					hdr_word = {hdr_word[15:0], b};
					hdr_cnt++;
				end else begin
					open_record(b);
					if (body_left == 0) close_record();
				end
			end else begin
				body_left--;
				body_data(b);
				if (body_left == 0) close_record();
			end
			if (eob && !verdict_done) expect_verdict(ST_SHORT, 16'd0);
		end
		if (eob) clear_state();
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (results_due.size() == 0) begin
				$error("result with nothing expected: %h", result_data);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("kind", 16'(want.kind), 16'(result_data.kind));
				check_field("payload_byte", 16'(want.payload_byte),
					16'(result_data.payload_byte));
				check_field("cookie_slot", 16'(want.cookie_slot),
					16'(result_data.cookie_slot));
				check_field("last_of_field", 16'(want.last_of_field),
					16'(result_data.last_of_field));
				check_field("status", 16'(want.status), 16'(result_data.status));
				check_field("server_error_code", want.server_error_code,
					result_data.server_error_code);
				check_field("chosen_aead", want.chosen_aead, result_data.chosen_aead);
				check_field("server_port", want.server_port, result_data.server_port);
				check_field("cookies_kept", 16'(want.cookies_kept),
					16'(result_data.cookies_kept));
				check_field("is_last", 16'(want.is_last), 16'(result_data.is_last));
			end
		end
	end

	// receiver: random stall runs, quiet stretches and requested long hold-offs
	initial begin : receiver_stall
		int   run;
		int   r;
		logic val;
		run = 0;
		val = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (run == 0) begin
				r = $urandom_range(0, 99);
				if (hold_req) begin
					val = 1'b1;
					run = hold_len;
					hold_req = 0;
				end else if (receiver_calm) begin
					val = 1'b0;
					run = 1;
				end else if (r < 45) begin
					val = 1'b0;
					run = $urandom_range(1, 6);
				end else if (r < 85) begin
					val = 1'b1;
					run = $urandom_range(1, 3);
				end else if (r < 97) begin
					val = 1'b0;
					run = $urandom_range(10, 30);
				end else begin
					val = 1'b1;
					run = $urandom_range(15, 40);
				end
			end
			result_stall <= val;
			run--;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_byte(logic [7:0] b, logic eob);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 55) gap = 0;
		else if (r < 90) gap = $urandom_range(1, 3);
		else if (r < 97) gap = $urandom_range(4, 8);
		else gap = $urandom_range(15, 30);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_data <= '{data_byte: b, end_of_buffer: eob};
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		parse_byte(b, eob);
	endtask

	task automatic send_msg();
		int n;
		n = msg_q.size();
		for (int i = 0; i < n; i++)
			send_byte(msg_q[i], i == n - 1);
		msg_q.delete();
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		// an ignored byte may still be in flight
		repeat (8) @(posedge clk);
	endtask

	task automatic set_aead_regs(logic [15:0] first, logic [15:0] second, logic [15:0] third);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_AEAD_FIRST;
		cfg_data <= first;
		@(posedge clk);
		cfg_index <= CFG_AEAD_SECOND;
		cfg_data <= second;
		@(posedge clk);
		cfg_index <= CFG_AEAD_THIRD;
		cfg_data <= third;
		@(posedge clk);
		cfg_we <= 1'b0;
		aead_cfg[0] = first;
		aead_cfg[1] = second;
		aead_cfg[2] = third;
	endtask

	function automatic void rec_head(logic crit, logic [14:0] k, logic [15:0] len);
		msg_q.push_back({crit, k[14:8]});
		msg_q.push_back(k[7:0]);
		msg_q.push_back(len[15:8]);
		msg_q.push_back(len[7:0]);
	endfunction

	function automatic void push_word(logic [15:0] w);
		msg_q.push_back(w[15:8]);
		msg_q.push_back(w[7:0]);
	endfunction

	function automatic void word_rec(logic [14:0] k, logic [15:0] w);
		rec_head($urandom_range(0, 4) == 0, k, 16'd2);
		push_word(w);
	endfunction

	function automatic void good_open(logic [15:0] aead);
		word_rec(RK_PROTOCOL, PROTO_NTPV4);
		word_rec(RK_AEAD, aead);
	endfunction

	function automatic void end_rec();
		rec_head(1'b0, RK_END, 16'd0);
	endfunction

	function automatic void cookie_rec(int len);
		rec_head($urandom_range(0, 4) == 0, RK_COOKIE, 16'(len));
		repeat (len) msg_q.push_back(8'($urandom));
	endfunction

	function automatic void name_rec(int len, int bad_at);
		rec_head($urandom_range(0, 4) == 0, RK_NAME, 16'(len));
		for (int i = 0; i < len; i++) begin
			if (i == bad_at)
				msg_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h20)) :
					8'($urandom_range(8'h7F, 8'hFF)));
			else
				msg_q.push_back(8'($urandom_range(NAME_MIN, NAME_MAX)));
		end
	endfunction

	// mostly well-formed messages with random content, some cut short, some noise
	function automatic void build_session();
		int r;
		int n;
		int extra;
		int pick;
		r = $urandom_range(0, 99);
		if (r >= 88) begin
			repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom));
			return;
		end
		if ($urandom_range(0, 9) != 0) begin
			n = $urandom_range(1, 3);
			rec_head($urandom_range(0, 4) == 0, RK_PROTOCOL, 16'(2 * n));
			repeat (n) push_word($urandom_range(0, 2) == 0 ? 16'($urandom) : PROTO_NTPV4);
		end
		if ($urandom_range(0, 9) != 0) begin
			n = $urandom_range(1, 2);
			rec_head($urandom_range(0, 4) == 0, RK_AEAD, 16'(2 * n));
			repeat (n) begin
				pick = $urandom_range(0, 5);
				push_word(pick < 2 ? aead_cfg[0] : pick == 2 ? aead_cfg[1] :
					pick == 3 ? aead_cfg[2] : pick == 4 ? 16'($urandom) : 16'd0);
			end
		end
		extra = ($urandom_range(0, 99) < 15) ? $urandom_range(6, 11) : $urandom_range(0, 5);
		repeat (extra) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				cookie_rec($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 10));
			else if (pick < 55) begin
				n = $urandom_range(1, 12);
				name_rec(n, $urandom_range(0, 9) == 0 ? $urandom_range(0, n - 1) : -1);
			end else if (pick < 70)
				word_rec(RK_PORT, 16'($urandom));
			else if (pick < 76)
				word_rec(RK_WARNING, 16'($urandom));
			else if (pick < 82)
				word_rec(RK_ERROR, 16'($urandom));
			else if (pick < 93) begin
				// unknown kind, critical in a few cases
				n = $urandom_range(0, 4);
				rec_head(pick >= 90, 15'($urandom_range(8, 15'h7FFF)), 16'(n));
				repeat (n) msg_q.push_back(8'($urandom));
			end else begin
				n = $urandom_range(0, 1) ? 1 : 3;
				rec_head(1'b0, $urandom_range(0, 1) ? RK_PORT : RK_WARNING, 16'(n));
				repeat (n) msg_q.push_back(8'($urandom));
			end
		end
		if ($urandom_range(0, 9) != 0) end_rec();
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom));
		if (msg_q.size() == 0) end_rec();
		if (r >= 75) begin
			n = $urandom_range(1, msg_q.size());
			while (msg_q.size() > n) void'(msg_q.pop_back());
		end
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_sessions();
		// complete exchange with every kept field
		good_open(AEAD_FIRST_RST);
		word_rec(RK_PORT, 16'd123);
		cookie_rec(3);
		name_rec(2, -1);
		end_rec();
		send_msg();
		good_open(AEAD_SECOND_RST);
		end_rec();
		send_msg();
		// only the first aead id of a record counts
		rec_head(1'b0, RK_PROTOCOL, 16'd4);
		push_word(16'h8001);
		push_word(PROTO_NTPV4);
		rec_head(1'b1, RK_AEAD, 16'd4);
		push_word(16'h0099);
		push_word(AEAD_FIRST_RST);
		end_rec();
		send_msg();
		word_rec(RK_PROTOCOL, 16'd5);
		end_rec();
		send_msg();
		rec_head(1'b0, RK_PROTOCOL, 16'd0);
		send_msg();
		word_rec(RK_PROTOCOL, PROTO_NTPV4);
		rec_head(1'b0, RK_AEAD, 16'd0);
		end_rec();
		send_msg();
		good_open(16'd0);
		end_rec();
		send_msg();
		// buffer ends on a record boundary with no end record
		good_open(AEAD_FIRST_RST);
		send_msg();
		end_rec();
		send_msg();
		msg_q.push_back(8'hFF);
		send_msg();
		// trailing bytes after the verdict
		good_open(AEAD_FIRST_RST);
		end_rec();
		repeat (5) msg_q.push_back(8'($urandom));
		send_msg();
	endtask

	task automatic test_error_records();
		word_rec(RK_ERROR, 16'h0000);
		send_msg();
		rec_head(1'b1, RK_ERROR, 16'd2);
		push_word(16'hFFFF);
		send_msg();
		word_rec(RK_WARNING, 16'h1234);
		send_msg();
		rec_head(1'b0, RK_ERROR, 16'd3);
		repeat (3) msg_q.push_back(8'($urandom));
		send_msg();
		// length fault pending but the buffer runs out first
		good_open(AEAD_FIRST_RST);
		rec_head(1'b0, RK_PORT, 16'd3);
		push_word(16'h1111);
		send_msg();
		rec_head(1'b0, RK_END, 16'd1);
		msg_q.push_back(8'h00);
		send_msg();
		rec_head(1'b0, RK_PROTOCOL, 16'd3);
		repeat (3) msg_q.push_back(8'h00);
		send_msg();
		good_open(AEAD_FIRST_RST);
		rec_head(1'b1, 15'h7FFF, 16'd1);
		msg_q.push_back(8'hA5);
		send_msg();
		good_open(AEAD_FIRST_RST);
		rec_head(1'b0, 15'd8, 16'd3);
		repeat (3) msg_q.push_back(8'($urandom));
		word_rec(RK_PORT, 16'hFFFF);
		end_rec();
		send_msg();
	endtask

	task automatic test_cookies_and_names();
		// nine cookies, one empty: the ninth is dropped
		good_open(AEAD_FIRST_RST);
		for (int i = 0; i < 9; i++) cookie_rec(i == 2 ? 0 : 2);
		end_rec();
		send_msg();
		good_open(AEAD_FIRST_RST);
		rec_head(1'b0, RK_NAME, 16'd2);
		msg_q.push_back(NAME_MIN);
		msg_q.push_back(NAME_MAX);
		end_rec();
		send_msg();
		good_open(AEAD_FIRST_RST);
		rec_head(1'b0, RK_NAME, 16'd4);
		msg_q.push_back(8'h61);
		msg_q.push_back(8'h62);
		msg_q.push_back(8'h20);
		msg_q.push_back(8'h63);
		end_rec();
		send_msg();
		good_open(AEAD_FIRST_RST);
		rec_head(1'b0, RK_NAME, 16'd2);
		msg_q.push_back(8'h7F);
		msg_q.push_back(8'h61);
		send_msg();
		good_open(AEAD_FIRST_RST);
		name_rec(MAX_NAME, -1);
		end_rec();
		send_msg();
		good_open(AEAD_FIRST_RST);
		name_rec(MAX_NAME + 1, -1);
		end_rec();
		send_msg();
		good_open(AEAD_FIRST_RST);
		rec_head(1'b0, RK_NAME, 16'hFFFF);
		repeat (5) msg_q.push_back(8'h41);
		send_msg();
	endtask

	task automatic test_aead_registers();
		logic [15:0] ids [4] = '{16'hFFFF, 16'h0001, 16'h8000, AEAD_FIRST_RST};
		set_aead_regs(16'hFFFF, 16'h0001, 16'h8000);
		foreach (ids[i]) begin
			good_open(ids[i]);
			end_rec();
			send_msg();
		end
		set_aead_regs(16'h0000, 16'h0000, 16'h0000);
		good_open(16'h0000);
		end_rec();
		send_msg();
		good_open(AEAD_FIRST_RST);
		end_rec();
		send_msg();
		set_aead_regs(AEAD_FIRST_RST, AEAD_SECOND_RST, AEAD_THIRD_RST);
	endtask

	task automatic test_backpressure();
		drain();
		sender_calm = 1;
		hold_len = 300;
		hold_req = 1;
		while (hold_req) @(posedge clk);
		// cookies give a result per byte, so the queue fills during the hold
		good_open(AEAD_SECOND_RST);
		repeat (6) cookie_rec(12);
		end_rec();
		send_msg();
		sender_calm = 0;
	endtask

	task automatic test_random_traffic();
		int phase_bytes;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_aead_regs(AEAD_FIRST_RST, AEAD_SECOND_RST, AEAD_THIRD_RST);
				1: set_aead_regs(16'h0000, 16'h0000, 16'h0000);
				2: set_aead_regs(16'hFFFF, 16'h0001, 16'h8000);
				default: set_aead_regs(16'($urandom), 16'($urandom),
					$urandom_range(0, 1) ? 16'h0000 : 16'($urandom));
			endcase
			phase_bytes = 0;
			while (phase_bytes < 50) begin
				// a stretch with no idling on either side
				sender_calm = (phase == 3) && (phase_bytes < 25);
				receiver_calm = sender_calm;
				build_session();
				phase_bytes += msg_q.size();
				send_msg();
			end
			sender_calm = 0;
			receiver_calm = 0;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_AEAD_FIRST;
		cfg_data <= '0;
		clear_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sessions();
		test_error_records();
		test_cookies_and_names();
		test_aead_registers();
		test_backpressure();
		test_random_traffic();
		byte_valid <= 1'b0;
		for (int i = 0; i < 5000 && results_due.size() != 0; i++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d expected results never arrived", results_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### nts_ke_response_record_parser_core.f
hdl/kerp_pkg.sv
hdl/nts_ke_response_record_parser_core.sv
dv/nts_ke_response_record_parser_core_tb.sv
